/* hdl/pcmfc_pkg.sv */
// Shared types and constants for the PCM sample format converter.
// No dependencies; imported by pcmfc_decode and pcm_sample_format_converter.
package pcmfc_pkg;

  // Format codes
  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S16 = 3'd1;
  localparam logic [2:0] FMT_S24 = 3'd2;
  localparam logic [2:0] FMT_S32 = 3'd3;
  localparam logic [2:0] FMT_F32 = 3'd4;

  // Config register indexes
  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_DEST   = 1'b1;

  typedef struct packed {
    logic [31:0] sample_in;
    logic        last_in;
  } in_word_t;

  typedef struct packed {
    logic [31:0] sample_out;
    logic        last_out;
  } out_word_t;

  // Normalized sample: (-1)^neg * mag / (den * 2^sh), den is 255 or 1
  typedef struct packed {
    logic        neg;
    logic        nan;
    logic        den255;
    logic [31:0] mag;
    logic [7:0]  sh;
  } norm_t;

endpackage

/* hdl/pcmfc_decode.sv */
// Source decoder: raw sample bits to sign/magnitude normalized form.
// Depends on pcmfc_pkg.
module pcmfc_decode import pcmfc_pkg::*; (
  input  logic [2:0]  source_format,
  input  logic [31:0] raw,
  output norm_t       norm
);

  logic [8:0]  v2;
  logic [7:0]  fe;
  logic [22:0] ff;

  always_comb begin
    v2 = {raw[7:0], 1'b0};
    fe = raw[30:23];
    ff = raw[22:0];
    norm = '0;
    case (source_format)
      FMT_U8: begin
        norm.den255 = 1'b1;
        if (v2 >= 9'd255) begin
          norm.mag = {23'd0, v2 - 9'd255};
        end else begin
          norm.mag = {23'd0, 9'd255 - v2};
          norm.neg = 1'b1;
        end
      end
      FMT_S16: begin
        norm.sh  = 8'd15;
        norm.neg = raw[15];
        norm.mag = {15'd0, raw[15] ? 17'h10000 - {1'b0, raw[15:0]} : {1'b0, raw[15:0]}};
      end
      FMT_S24: begin
        norm.sh  = 8'd23;
        norm.neg = raw[23];
        norm.mag = {7'd0, raw[23] ? 25'h1000000 - {1'b0, raw[23:0]} : {1'b0, raw[23:0]}};
      end
      FMT_S32: begin
        norm.sh  = 8'd31;
        norm.neg = raw[31];
        norm.mag = raw[31] ? (~raw + 32'd1) : raw;
      end
      FMT_F32: begin
        norm.neg = raw[31];
        if (fe == 8'hFF && ff != 23'd0) begin
          norm.nan = 1'b1;
          norm.neg = 1'b0;
        end else if (fe >= 8'd128) begin
          // |s| >= 2 or inf: every output saturates, so stand in with 2
          norm.mag = 32'd2;
        end else if (fe == 8'd0) begin
          norm.mag = {9'd0, ff};
          norm.sh  = 8'd149;
        end else begin
          norm.mag = {8'd0, 1'b1, ff};
          norm.sh  = 8'd150 - fe;
        end
      end
      default: begin
      end
    endcase
    if (norm.mag == 32'd0) norm.neg = 1'b0;
  end

endmodule

/* hdl/pcm_sample_format_converter.sv */
// PCM sample format converter, top level.
// Depends on pcmfc_pkg and pcmfc_decode.
//
// Converts one audio sample per word between u8, s16, s24, s32 and float32
// as chosen by source_format and dest_format (config indexes 0 and 1, both
// reset to s16; write them only while no word is in flight). Equal formats
// pass the raw bits through, masked to the format width; an unknown
// destination code gives zero. Integer outputs round half away from zero
// and saturate, float output rounds to nearest even, NaN gives the zero code
// (128 for u8). The datapath is three register stages: decode, scale
// (shift, divide-by-255 via byte replication, leading-one search), and
// finish (round, saturate, float mantissa shift). A word taken into the
// decode register moves through the scale and finish registers before
// dst_valid shows it; throughput is one word per cycle while dst_ready is high. Each stage
// has its own valid bit and fills whenever the stage after it is empty or
// moving, so bubbles are squeezed out under backpressure on dst_ready.
module pcm_sample_format_converter import pcmfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [2:0] cfg_data,
  input  logic      src_valid,
  output logic      src_ready,
  input  in_word_t  src_word,
  output logic      dst_valid,
  input  logic      dst_ready,
  output out_word_t dst_word
);

  // Config registers
  logic [2:0] source_format;
  logic [2:0] dest_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_S16;
      dest_format   <= FMT_S16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE: source_format <= cfg_data;
        CFG_DEST:   dest_format   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stage handshake: a stage loads when it is empty or its word moves on
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !v3 || dst_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign src_ready = rdy1;
  assign dst_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= src_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // ---------------- Stage 1: decode ----------------
  norm_t       norm_d;
  logic        passsel_d;
  logic [31:0] pass_d;

  pcmfc_decode u_decode (
    .source_format(source_format),
    .raw          (src_word.sample_in),
    .norm         (norm_d)
  );

  always_comb begin
    passsel_d = (dest_format > FMT_F32) || (source_format == dest_format);
    case (dest_format)
      FMT_U8:  pass_d = {24'd0, src_word.sample_in[7:0]};
      FMT_S16: pass_d = {16'd0, src_word.sample_in[15:0]};
      FMT_S24: pass_d = {8'd0, src_word.sample_in[23:0]};
      FMT_S32: pass_d = src_word.sample_in;
      FMT_F32: pass_d = src_word.sample_in;
      default: pass_d = 32'd0;
    endcase
  end

  norm_t       n1;
  logic        passsel1, last1;
  logic [31:0] pass1;

  always_ff @(posedge clk) begin
    if (rdy1 && src_valid) begin
      n1       <= norm_d;
      passsel1 <= passsel_d;
      pass1    <= pass_d;
      last1    <= src_word.last_in;
    end
  end

  // ---------------- Stage 2: scale ----------------
  logic [7:0]  mag8;
  logic [5:0]  jbits;      // k+1 for the integer destination
  logic [33:0] xi;         // floor(|s| * 2^(k+1))
  logic [39:0] t255;       // mag * 255
  logic [39:0] p0;
  logic        rem_c;
  logic [8:0]  qs_c;       // quotient for u8, saturated at 256
  logic [40:0] y_c;        // float significand source
  logic        sticky_c;
  logic [7:0]  base_c;     // 127 + binary exponent of y's bit 0
  logic [5:0]  p_c;        // leading one position of y

  always_comb begin
    mag8 = n1.mag[7:0];
    case (dest_format)
      FMT_S16: jbits = 6'd16;
      FMT_S24: jbits = 6'd24;
      default: jbits = 6'd32;
    endcase

    // integer path; 2^j = 255*A + 1 for j a multiple of 8, A = 0x0101..
    if (n1.den255) begin
      case (dest_format)
        FMT_S16: xi = {18'd0, mag8, mag8};
        FMT_S24: xi = {10'd0, mag8, mag8, mag8};
        default: xi = {2'd0, mag8, mag8, mag8, mag8};
      endcase
      if (mag8 == 8'hFF) xi = 34'd1 << jbits;
    end else if (n1.sh <= {2'b00, jbits}) begin
      xi = {2'b00, n1.mag} << (jbits - n1.sh[5:0]);
    end else begin
      xi = {2'b00, n1.mag} >> (n1.sh - {2'b00, jbits});
    end

    // u8 path (source is never u8 here)
    t255  = {n1.mag, 8'd0} - {8'd0, n1.mag};
    p0    = t255 >> n1.sh;
    rem_c = (t255 & ~(40'hFF_FFFF_FFFF << n1.sh)) != 40'd0;
    qs_c  = (p0 > 40'd255) ? 9'd256 : {1'b0, p0[7:0]};

    // float path; for u8 source y = mag * 2^40 / 255
    if (n1.den255) begin
      if (mag8 == 8'hFF) y_c = 41'h100_0000_0000;
      else               y_c = {1'b0, mag8, mag8, mag8, mag8, mag8};
      sticky_c = (mag8 != 8'hFF);
      base_c   = 8'd87;
    end else begin
      y_c      = {9'd0, n1.mag};
      sticky_c = 1'b0;
      base_c   = 8'd127 - n1.sh;
    end
    p_c = 6'd0;
    for (int i = 0; i < 41; i++) begin
      if (y_c[i]) p_c = 6'(i);
    end
  end

  logic [33:0] x2;
  logic [8:0]  qs2;
  logic        rem2, sticky2, neg2, nan2, passsel2, last2;
  logic [40:0] y2;
  logic [5:0]  p2;
  logic [7:0]  base2;
  logic [31:0] pass2;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      x2       <= xi;
      qs2      <= qs_c;
      rem2     <= rem_c;
      y2       <= y_c;
      sticky2  <= sticky_c;
      p2       <= p_c;
      base2    <= base_c;
      neg2     <= n1.neg;
      nan2     <= n1.nan;
      passsel2 <= passsel1;
      pass2    <= pass1;
      last2    <= last1;
    end
  end

  // ---------------- Stage 3: finish ----------------
  logic [33:0] m_i, lim_i, msat, mask_i, neg_i;
  logic [31:0] res_int;
  logic [7:0]  qc;
  logic [8:0]  u8_sum;
  logic [9:0]  c_u8;
  logic [8:0]  u8_dn;
  logic [31:0] res_u8;
  logic [5:0]  sh2;
  logic [40:0] yr;
  logic [24:0] mf;
  logic        rb, rest;
  logic [7:0]  pe;
  logic [31:0] res_f32;
  logic [31:0] res_c;

  always_comb begin
    // integer: round half up on magnitude, saturate, apply sign
    m_i = (x2 + 34'd1) >> 1;
    mask_i = (34'd1 << jbits) - 34'd1;
    lim_i  = neg2 ? (34'd1 << (jbits - 6'd1)) : ((34'd1 << (jbits - 6'd1)) - 34'd1);
    msat   = (m_i > lim_i) ? lim_i : m_i;
    neg_i  = (~msat + 34'd1) & mask_i;
    if (nan2)      res_int = 32'd0;
    else if (neg2) res_int = neg_i[31:0];
    else           res_int = msat[31:0];

    // u8
    qc     = (qs2 > 9'd255) ? 8'd255 : qs2[7:0];
    u8_sum = ({1'b0, qc} + 9'd256) >> 1;
    c_u8   = {1'b0, qs2} + {9'd0, rem2};
    u8_dn  = (9'd254 - c_u8[8:0]) >> 1;
    if (nan2)                  res_u8 = 32'd128;
    else if (!neg2)            res_u8 = {24'd0, u8_sum[7:0]};
    else if (c_u8 >= 10'd255)  res_u8 = 32'd0;
    else                       res_u8 = {24'd0, u8_dn[7:0]};

    // float: align to 24 bits, round to nearest even
    sh2  = p2 - 6'd23;
    rb   = 1'b0;
    rest = 1'b0;
    pe   = {2'b00, p2};
    if (p2 <= 6'd23) begin
      yr = y2 << (6'd23 - p2);
      mf = yr[24:0];
    end else begin
      yr   = y2 >> sh2;
      mf   = yr[24:0];
      rb   = y2[sh2 - 6'd1];
      rest = ((y2 & ~(41'h1FF_FFFF_FFFF << (sh2 - 6'd1))) != 41'd0) || sticky2;
      if (rb && (rest || mf[0])) mf = mf + 25'd1;
      if (mf[24]) begin
        mf = mf >> 1;
        pe = pe + 8'd1;
      end
    end
    if (nan2 || y2 == 41'd0) res_f32 = 32'd0;
    else                     res_f32 = {neg2, pe + base2, mf[22:0]};

    if (passsel2) begin
      res_c = pass2;
    end else begin
      case (dest_format)
        FMT_U8:  res_c = res_u8;
        FMT_F32: res_c = res_f32;
        default: res_c = res_int;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      dst_word.sample_out <= res_c;
      dst_word.last_out   <= last2;
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the PCM sample format converter: random and directed samples
// across random format pairs, checked against an exact fixed-point predictor.
// Depends on pcmfc_pkg and pcm_sample_format_converter.
module tb_top;
  import pcmfc_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic      cfg_index = 1'b0;
  logic [2:0] cfg_data = '0;
  logic      src_valid = 1'b0;
  logic      src_ready;
  in_word_t  src_word = '0;
  logic      dst_valid;
  logic      dst_ready = 1'b0;
  out_word_t dst_word;

  pcm_sample_format_converter DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .src_valid(src_valid), .src_ready(src_ready), .src_word(src_word),
    .dst_valid(dst_valid), .dst_ready(dst_ready), .dst_word(dst_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor's copy of the two format registers
  logic [2:0] cur_src = FMT_S16;
  logic [2:0] cur_dst = FMT_S16;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        mismatches = 0;
  bit        timed_out = 1'b0;
  bit        src_hold = 1'b0;
  longint    cycles = 0;
  int        src_taken_cnt = 0;
  int        src_seen_cnt = 0;

  // Normalized value: (-1)^neg * mag / (den * 2^sh)
  typedef struct {
    bit       neg;
    bit       nan;
    bit [63:0] mag;
    bit [63:0] den;
    int       sh;
  } norm_val_t;

  function automatic bit [63:0] rshift(bit [63:0] v, int sh);
    return (sh >= 64) ? 64'd0 : (v >> sh);
  endfunction

  function automatic norm_val_t decode_sample(logic [31:0] raw);
    norm_val_t s;
    bit [63:0] v;
    int e;
    s.neg = 0; s.nan = 0; s.mag = 0; s.den = 1; s.sh = 0;
    case (cur_src)
      FMT_U8: begin
        v = 2 * raw[7:0];
        s.den = 255;
        if (v >= 255) s.mag = v - 255;
        else begin
          s.mag = 255 - v; s.neg = 1;
        end
      end
      FMT_S16: begin
        v = raw[15:0]; s.sh = 15;
        if (v[15]) begin
          s.neg = 1; s.mag = 64'h10000 - v;
        end else s.mag = v;
      end
      FMT_S24: begin
        v = raw[23:0]; s.sh = 23;
        if (v[23]) begin
          s.neg = 1; s.mag = 64'h1000000 - v;
        end else s.mag = v;
      end
      FMT_S32: begin
        v = raw; s.sh = 31;
        if (v[31]) begin
          s.neg = 1; s.mag = 64'h100000000 - v;
        end else s.mag = v;
      end
      FMT_F32: begin
        e = raw[30:23];
        v = raw[22:0];
        s.neg = raw[31];
        if (e == 255 && v != 0) begin
          s.nan = 1; s.neg = 0;
        end else if (e >= 128) begin
          s.mag = 2; s.sh = 0;   // |s| >= 2 saturates everywhere
        end else if (e == 0) begin
          s.mag = v; s.sh = 149;
        end else begin
          s.mag = v | 64'h800000; s.sh = 150 - e;
        end
      end
      default: ;
    endcase
    if (s.mag == 0) s.neg = 0;
    return s;
  endfunction

  function automatic logic [31:0] encode_int(norm_val_t s, int k);
    bit [63:0] x, m, lim, mask;
    if (s.nan) return 32'd0;
    if (s.sh <= k + 1) x = s.mag << (k + 1 - s.sh);
    else x = rshift(s.mag, s.sh - k - 1);
    x = x / s.den;
    m = (x + 1) >> 1;
    lim = s.neg ? (64'd1 << k) : ((64'd1 << k) - 1);
    if (m > lim) m = lim;
    mask = (64'd1 << (k + 1)) - 1;
    return 32'(s.neg ? ((64'd0 - m) & mask) : m);
  endfunction

  function automatic logic [31:0] encode_u8(norm_val_t s);
    bit [63:0] t, p0, q, c;
    bit rem;
    if (s.nan) return 32'd128;
    t = s.mag * 255;
    p0 = rshift(t, s.sh);
    if (s.sh >= 64) rem = (t != 0);
    else rem = (t & ((64'd1 << s.sh) - 1)) != 0;
    q = p0 / s.den;
    rem = rem || (p0 % s.den) != 0;
    if (!s.neg) begin
      if (q > 255) q = 255;
      return 32'((q + 256) >> 1);
    end
    c = q + rem;
    if (c >= 255) return 32'd0;
    return 32'((254 - c) >> 1);
  endfunction

  function automatic logic [31:0] encode_float(norm_val_t s);
    bit [63:0] y, m, low;
    bit sticky, rb, rest;
    int e2, p, sh;
    sticky = 0; p = 0;
    if (s.nan || s.mag == 0) return 32'd0;
    if (s.den == 1) begin
      y = s.mag; e2 = -s.sh;
    end else begin
      y = (s.mag << 40) / s.den;
      sticky = ((s.mag << 40) % s.den) != 0;
      e2 = -40 - s.sh;
    end
    while (p < 63 && (y >> (p + 1)) != 0) p++;
    if (p <= 23) m = y << (23 - p);
    else begin
      sh = p - 23;
      m = y >> sh;
      rb = y[sh - 1];
      low = (sh == 1) ? 64'd0 : (y & ((64'd1 << (sh - 1)) - 1));
      rest = (low != 0) || sticky;
      if (rb && (rest || m[0])) m++;
      if (m == (64'd1 << 24)) begin
        m >>= 1; p++;
      end
    end
    return {s.neg, 8'(p + e2 + 127), m[22:0]};
  endfunction

  function automatic out_word_t convert_sample(in_word_t w);
    out_word_t r;
    norm_val_t s;
    r.last_out = w.last_in;
    r.sample_out = '0;
    if (cur_dst > FMT_F32) r.sample_out = '0;
    else if (cur_src == cur_dst) begin
      case (cur_dst)
        FMT_U8:  r.sample_out = w.sample_in & 32'hFF;
        FMT_S16: r.sample_out = w.sample_in & 32'hFFFF;
        FMT_S24: r.sample_out = w.sample_in & 32'hFFFFFF;
        default: r.sample_out = w.sample_in;
      endcase
    end else begin
      s = decode_sample(w.sample_in);
      case (cur_dst)
        FMT_U8:  r.sample_out = encode_u8(s);
        FMT_S16: r.sample_out = encode_int(s, 15);
        FMT_S24: r.sample_out = encode_int(s, 23);
        FMT_S32: r.sample_out = encode_int(s, 31);
        default: r.sample_out = encode_float(s);
      endcase
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Acceptance is seen at the rising edge; expectation queued there
  always @(posedge clk) begin
    if (!rst && src_valid && src_ready) begin
      expected_words.push_back(convert_sample(src_word));
      src_taken_cnt++;
    end
  end

  // Driver: one word in flight on src
  int src_gap = 0;
  always @(negedge clk) begin
    bit taken;
    taken = (src_taken_cnt != src_seen_cnt);
    src_seen_cnt = src_taken_cnt;
    if (!rst) begin
      if (src_valid && !taken) begin
        // hold
      end else begin
        if (taken) src_gap = pick_gap();
        if (src_gap > 0) begin
          src_gap--;
          src_valid <= 1'b0;
        end else if (!src_hold && pending_words.size() > 0) begin
          src_word <= pending_words.pop_front();
          src_valid <= 1'b1;
        end else src_valid <= 1'b0;
      end
    end
  end

  // Sink stall pattern
  int dst_gap = 0;
  always @(negedge clk) begin
    if (dst_gap > 0) begin
      dst_gap--;
      dst_ready <= 1'b0;
    end else begin
      dst_ready <= 1'b1;
      dst_gap = pick_gap();
    end
  end

  // Monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    out_word_t exp_w;
    cycles <= cycles + 1;
    if (!rst && dst_valid && dst_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", dst_word);
      end else begin
        exp_w = expected_words.pop_front();
        if (exp_w.sample_out !== dst_word.sample_out ||
            exp_w.last_out !== dst_word.last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sample %h last %b, got sample %h last %b",
                     exp_w.sample_out, exp_w.last_out,
                     dst_word.sample_out, dst_word.last_out);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > 200000) begin
      timed_out = 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || src_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Register writes are driven at the falling edge and taken at the rising edge; predictor copy follows.
  task automatic set_formats(logic [2:0] sf, logic [2:0] df);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_SOURCE; cfg_data <= sf;
    @(negedge clk);
    cfg_index <= CFG_DEST; cfg_data <= df;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_src = sf;
    cur_dst = df;
  endtask

  function automatic logic [31:0] rand_sample(logic [2:0] sf);
    int r;
    logic [31:0] v;
    v = $urandom();
    r = $urandom_range(0, 9);
    if (sf == FMT_F32) begin
      case (r)
        0: v = {v[31], 8'hFF, 23'd0};                 // infinity
        1: v = {v[31], 8'hFF, v[22:1], 1'b1};         // NaN
        2: v = {v[31], 8'h00, v[22:0]};               // subnormal
        3: v = {v[31], 31'd0};                        // signed zero
        4: v = {v[31], 8'($urandom_range(120, 127)), v[22:0]}; // near unity
        5: v = {v[31], 8'($urandom_range(128, 140)), v[22:0]}; // beyond range
        default: v = {v[31], 8'($urandom_range(90, 127)), v[22:0]};
      endcase
    end else if (r == 0) v = 32'h80000000;
    else if (r == 1) v = 32'h7FFFFFFF;
    return v;
  endfunction

  function automatic in_word_t mk(logic [31:0] smp, logic lst);
    in_word_t w;
    w.sample_in = smp;
    w.last_in = lst;
    return w;
  endfunction

  initial begin
    logic [31:0] edge_vals[$];
    logic [2:0] sf, df;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes and specials at reset setting, then float to u8
    edge_vals = '{32'h0, 32'hFFFFFFFF, 32'h00007FFF, 32'h00008000, 32'h00000080,
                  32'h000000FF, 32'h007FFFFF, 32'h00800000, 32'h7FFFFFFF, 32'h80000000,
                  32'h3F800000, 32'hBF800000, 32'h7FC00001, 32'h80000000,
                  32'h7F800000, 32'h00000001, 32'h3F000000};
    foreach (edge_vals[i]) pending_words.push_back(mk(edge_vals[i], i[0]));
    wait_drained();
    set_formats(FMT_F32, FMT_U8);
    foreach (edge_vals[i]) pending_words.push_back(mk(edge_vals[i], i[0]));
    wait_drained();
    // Unknown codes on both sides
    set_formats(3'd7, 3'd5);
    pending_words.push_back(mk(32'h12345678, 1'b1));
    wait_drained();
    set_formats(3'd6, FMT_F32);
    pending_words.push_back(mk(32'h12345678, 1'b0));
    wait_drained();

    // Random phases over random format pairs, extremes included
    for (int ph = 0; ph < 30; ph++) begin
      sf = (ph % 10 == 9) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      df = (ph % 10 == 7) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if (ph == 0) begin
        sf = FMT_U8; df = FMT_F32;
      end
      set_formats(sf, df);
      for (int i = 0; i < 15; i++)
        pending_words.push_back(mk(rand_sample(sf), $urandom_range(0, 1)));
      if (ph == 12) begin
        // Let part of the phase go out, then hold the sender until drained
        while (pending_words.size() > 7) @(posedge clk);
        src_hold = 1'b1;
        while (expected_words.size() > 0 || src_valid) @(posedge clk);
        src_hold = 1'b0;
      end
      wait_drained();
    end

    if (mismatches == 0 && !timed_out) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
